FILE: rtl/rrsp_pkg.sv
// Package for the reply stream parser: byte class record, phase and event codes.
// Used by the front and back modules and the top level.
package rrsp_pkg;

    localparam int DEPTH_W = 4;
    localparam int EV_W    = 4;

    // Event codes
    localparam logic [EV_W-1:0] EV_SBYTE  = 4'd0;
    localparam logic [EV_W-1:0] EV_EBYTE  = 4'd1;
    localparam logic [EV_W-1:0] EV_BBYTE  = 4'd2;
    localparam logic [EV_W-1:0] EV_SEND   = 4'd3;
    localparam logic [EV_W-1:0] EV_EEND   = 4'd4;
    localparam logic [EV_W-1:0] EV_INT    = 4'd5;
    localparam logic [EV_W-1:0] EV_BEND   = 4'd6;
    localparam logic [EV_W-1:0] EV_NULL   = 4'd7;
    localparam logic [EV_W-1:0] EV_AOPEN  = 4'd8;
    localparam logic [EV_W-1:0] EV_AEMPTY = 4'd9;
    localparam logic [EV_W-1:0] EV_PERR   = 4'd10;

    // Protocol characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLLR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    localparam logic [63:0] MAG_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_NEG_LIMIT = 64'h8000_0000_0000_0000;

    // Classified byte as held in the queue
    typedef struct packed {
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
        logic       is_minus;
        logic       is_digit;
        logic       is_print;
        logic       is_plus;
        logic       is_colon;
        logic       is_dollar;
        logic       is_star;
    } t_item;

    typedef enum logic [13:0] {
        PH_START    = 14'b00000000000001,
        PH_SIMPLE   = 14'b00000000000010,
        PH_ERR      = 14'b00000000000100,
        PH_SIMPLE_LF= 14'b00000000001000,
        PH_ERR_LF   = 14'b00000000010000,
        PH_INT      = 14'b00000000100000,
        PH_INT_LF   = 14'b00000001000000,
        PH_BLEN     = 14'b00000010000000,
        PH_BLEN_LF  = 14'b00000100000000,
        PH_BDATA    = 14'b00001000000000,
        PH_BCR      = 14'b00010000000000,
        PH_BLF      = 14'b00100000000000,
        PH_ALEN     = 14'b01000000000000,
        PH_ALEN_LF  = 14'b10000000000000
    } t_phase;

    typedef struct packed {
        logic [EV_W-1:0]    event_res;
        logic [7:0]         data_byte;
        logic signed [63:0] number;
        logic [DEPTH_W-1:0] nest_depth;
        logic               reply_done;
    } t_event;

endpackage

FILE: rtl/rrsp_byte_if.sv
// Input byte channel: valid/ready handshake carrying one stream byte.
// Stand-alone; no package dependency.
interface rrsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

FILE: rtl/rrsp_event_if.sv
// Result channel: valid/ready handshake carrying one parser event.
// Stand-alone; field widths follow the package constants.
interface rrsp_event_if;
    logic               valid;
    logic               ready;
    logic [3:0]         event_res;
    logic [7:0]         data_byte;
    logic signed [63:0] number;
    logic [3:0]         nest_depth;
    logic               reply_done;
    modport source (output valid, output event_res, output data_byte, output number,
                    output nest_depth, output reply_done, input ready);
    modport sink   (input valid, input event_res, input data_byte, input number,
                    input nest_depth, input reply_done, output ready);
endinterface

FILE: rtl/rrsp_front.sv
// Front end: accepts bytes, classifies them and holds them in a two-entry queue.
// Depends on rrsp_pkg.
module rrsp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    output logic          o_q_valid,
    output rrsp_pkg::t_item o_q_item,
    input  logic          i_q_pop
);
    import rrsp_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      cls;
    logic       push, pop;

    // Byte classification
    always_comb begin
        cls.data      = i_byte;
        cls.is_cr     = (i_byte == CH_CR);
        cls.is_lf     = (i_byte == CH_LF);
        cls.is_minus  = (i_byte == CH_MINUS);
        cls.is_digit  = (i_byte >= 8'h30) && (i_byte <= 8'h39);
        cls.is_print  = (i_byte >= 8'd32) && (i_byte <= 8'd126);
        cls.is_plus   = (i_byte == CH_PLUS);
        cls.is_colon  = (i_byte == CH_COLON);
        cls.is_dollar = (i_byte == CH_DOLLR);
        cls.is_star   = (i_byte == CH_STAR);
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cls;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: rtl/rrsp_back.sv
// Back end: parse state machine, nesting stack and output register.
// Depends on rrsp_pkg.
module rrsp_back #(
    parameter int MAX_NEST   = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  rrsp_pkg::t_item i_q_item,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output rrsp_pkg::t_event o_event
);
    import rrsp_pkg::*;

    localparam int IDX_W = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

    t_phase                  r_phase, n_phase;
    logic [63:0]             r_acc, n_acc;
    logic                    r_minus, n_minus;
    logic [4:0]              r_dcnt, n_dcnt;
    logic [COUNT_BITS-1:0]   r_brem, n_brem;
    logic [DEPTH_W-1:0]      r_lvl, n_lvl;
    logic [COUNT_BITS-1:0]   r_lvl_rem [MAX_NEST];
    logic                    r_ov;
    t_event                  r_ev;

    logic                    step;
    logic                    ev_v, do_fail;
    t_event                  ev;
    logic                    lvl_we;
    logic [IDX_W-1:0]        lvl_wa;
    logic [COUNT_BITS-1:0]   lvl_wd;
    logic [MAX_NEST-1:0]     lvl_one;
    logic [DEPTH_W-1:0]      pop_lvl;
    logic [67:0]             prod;
    logic [63:0]             limit;
    logic                    num_err;
    logic [63:0]             sval;
    logic                    too_big;
    t_item                   it;

    assign step    = i_q_valid && (!r_ov || i_ready);
    assign o_q_pop = step;
    assign o_valid = r_ov;
    assign o_event = r_ev;
    assign it      = i_q_item;

    // Digit accumulate with overflow check
    always_comb begin
        prod    = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {64'd0, it.data[3:0]};
        limit   = r_minus ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
        num_err = it.is_cr ? (r_dcnt == 5'd0)
                : it.is_minus ? (r_minus || (r_dcnt != 5'd0))
                : it.is_digit ? (prod > {4'd0, limit})
                : 1'b1;
        sval    = r_minus ? (64'd0 - r_acc) : r_acc;
        too_big = |r_acc[63:COUNT_BITS];
    end

    // Completion pops: levels holding one left are popped from the top
    always_comb begin
        for (int i = 0; i < MAX_NEST; i++) begin
            lvl_one[i] = (r_lvl_rem[i] == COUNT_BITS'(1));
        end
        pop_lvl = r_lvl;
        for (int k = MAX_NEST - 1; k >= 0; k--) begin
            if ((pop_lvl == DEPTH_W'(k + 1)) && lvl_one[k]) begin
                pop_lvl = DEPTH_W'(k);
            end
        end
    end

    // Parse state machine
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_minus = r_minus;
        n_dcnt  = r_dcnt;
        n_brem  = r_brem;
        n_lvl   = r_lvl;
        ev_v    = 1'b0;
        do_fail = 1'b0;
        ev.event_res  = EV_SBYTE;
        ev.data_byte  = 8'd0;
        ev.number     = 64'sd0;
        ev.nest_depth = r_lvl;
        ev.reply_done = 1'b0;
        lvl_we  = 1'b0;
        lvl_wa  = r_lvl[IDX_W-1:0];
        lvl_wd  = r_acc[COUNT_BITS-1:0];

        case (r_phase)
            PH_START: begin
                n_acc   = 64'd0;
                n_minus = 1'b0;
                n_dcnt  = 5'd0;
                if (it.is_plus)        n_phase = PH_SIMPLE;
                else if (it.is_minus)  n_phase = PH_ERR;
                else if (it.is_colon)  n_phase = PH_INT;
                else if (it.is_dollar) n_phase = PH_BLEN;
                else if (it.is_star)   n_phase = PH_ALEN;
                else do_fail = 1'b1;
            end
            PH_SIMPLE, PH_ERR: begin
                if (it.is_cr) begin
                    n_phase = (r_phase == PH_SIMPLE) ? PH_SIMPLE_LF : PH_ERR_LF;
                end else if (it.is_print) begin
                    ev_v = 1'b1;
                    ev.event_res = (r_phase == PH_SIMPLE) ? EV_SBYTE : EV_EBYTE;
                    ev.data_byte = it.data;
                end else begin
                    do_fail = 1'b1;
                end
            end
            PH_SIMPLE_LF, PH_ERR_LF, PH_INT_LF, PH_BLF: begin
                if (!it.is_lf) begin
                    do_fail = 1'b1;
                end else begin
                    ev_v = 1'b1;
                    ev.reply_done = (pop_lvl == '0);
                    n_lvl   = pop_lvl;
                    n_phase = PH_START;
                    if (pop_lvl != '0) begin
                        lvl_we = 1'b1;
                        lvl_wa = IDX_W'(pop_lvl - 1'b1);
                        lvl_wd = r_lvl_rem[IDX_W'(pop_lvl - 1'b1)] - 1'b1;
                    end
                    case (r_phase)
                        PH_SIMPLE_LF: ev.event_res = EV_SEND;
                        PH_ERR_LF:    ev.event_res = EV_EEND;
                        PH_INT_LF: begin
                            ev.event_res = EV_INT;
                            ev.number    = sval;
                        end
                        default: begin
                            ev.event_res = EV_BEND;
                            ev.number    = r_acc;
                        end
                    endcase
                end
            end
            PH_INT, PH_BLEN, PH_ALEN: begin
                if (num_err) begin
                    do_fail = 1'b1;
                end else if (it.is_cr) begin
                    n_phase = (r_phase == PH_INT) ? PH_INT_LF
                            : (r_phase == PH_BLEN) ? PH_BLEN_LF : PH_ALEN_LF;
                end else if (it.is_minus) begin
                    n_minus = 1'b1;
                end else begin
                    n_acc = prod[63:0];
                    if (r_dcnt != 5'd31) n_dcnt = r_dcnt + 5'd1;
                end
            end
            PH_BLEN_LF: begin
                if (!it.is_lf) begin
                    do_fail = 1'b1;
                end else if (r_minus && (r_acc != 64'd0)) begin
                    if (r_acc == 64'd1) begin
                        ev_v = 1'b1;
                        ev.event_res  = EV_NULL;
                        ev.number     = sval;
                        ev.reply_done = (pop_lvl == '0);
                        n_lvl   = pop_lvl;
                        n_phase = PH_START;
                        if (pop_lvl != '0) begin
                            lvl_we = 1'b1;
                            lvl_wa = IDX_W'(pop_lvl - 1'b1);
                            lvl_wd = r_lvl_rem[IDX_W'(pop_lvl - 1'b1)] - 1'b1;
                        end
                    end else begin
                        do_fail = 1'b1;
                    end
                end else if (too_big) begin
                    do_fail = 1'b1;
                end else begin
                    n_minus = 1'b0;
                    n_brem  = r_acc[COUNT_BITS-1:0];
                    n_phase = (r_acc == 64'd0) ? PH_BCR : PH_BDATA;
                end
            end
            PH_BDATA: begin
                n_brem = r_brem - 1'b1;
                if (r_brem == COUNT_BITS'(1)) n_phase = PH_BCR;
                ev_v = 1'b1;
                ev.event_res = EV_BBYTE;
                ev.data_byte = it.data;
            end
            PH_BCR: begin
                if (it.is_cr) n_phase = PH_BLF;
                else do_fail = 1'b1;
            end
            PH_ALEN_LF: begin
                if (!it.is_lf) begin
                    do_fail = 1'b1;
                end else if ((r_acc == 64'd0) || (r_minus && (r_acc == 64'd1))) begin
                    ev_v = 1'b1;
                    ev.event_res  = EV_AEMPTY;
                    ev.number     = sval;
                    ev.reply_done = (pop_lvl == '0);
                    n_lvl   = pop_lvl;
                    n_phase = PH_START;
                    if (pop_lvl != '0) begin
                        lvl_we = 1'b1;
                        lvl_wa = IDX_W'(pop_lvl - 1'b1);
                        lvl_wd = r_lvl_rem[IDX_W'(pop_lvl - 1'b1)] - 1'b1;
                    end
                end else if (r_minus || too_big || (r_lvl >= DEPTH_W'(MAX_NEST))) begin
                    do_fail = 1'b1;
                end else begin
                    ev_v = 1'b1;
                    ev.event_res = EV_AOPEN;
                    ev.number    = r_acc;
                    lvl_we  = 1'b1;
                    n_lvl   = r_lvl + 1'b1;
                    n_phase = PH_START;
                end
            end
            default: do_fail = 1'b1;
        endcase

        // Parse error: report and return to reset state
        if (do_fail) begin
            ev_v = 1'b1;
            ev.event_res  = EV_PERR;
            ev.data_byte  = 8'd0;
            ev.number     = 64'sd0;
            ev.reply_done = 1'b0;
            n_phase = PH_START;
            n_acc   = 64'd0;
            n_minus = 1'b0;
            n_dcnt  = 5'd0;
            n_brem  = '0;
            n_lvl   = '0;
            lvl_we  = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_acc   <= 64'd0;
            r_minus <= 1'b0;
            r_dcnt  <= 5'd0;
            r_brem  <= '0;
            r_lvl   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (step) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_minus <= n_minus;
                r_dcnt  <= n_dcnt;
                r_brem  <= n_brem;
                r_lvl   <= n_lvl;
                r_ov    <= ev_v;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Nesting stack and output payload
    always_ff @(posedge i_clk) begin
        if (step && lvl_we) begin
            r_lvl_rem[lvl_wa] <= lvl_wd;
        end
        if (step && ev_v) begin
            r_ev <= ev;
        end
    end
endmodule

FILE: rtl/resp_reply_stream_parser.sv
// Reply stream parser, top level.
// The byte channel (i_byte_if) takes one stream byte per transaction; the
// event channel (o_evt_if) gives at most one event per byte: content bytes,
// completions with their integer, length or count, array opens, and parse
// errors, each with the nesting depth and a flag for a finished top reply.
// Throughput: one byte per cycle while events are taken. Bytes pass a
// two-entry queue in the front end; the back end parses one byte per
// cycle into a registered output, so the event for a byte is offered
// from that output register once the byte has left the queue. A byte
// that yields no event still takes a step of the back end. When the
// receiver stalls, the held event waits, the back end stops and the
// queue fills; input ready drops once both entries are taken.
// Reset (synchronous, active low) empties the queue and the output and
// returns the parser to awaiting a type byte with no open array.
// Depends on rrsp_pkg, rrsp_byte_if, rrsp_event_if, rrsp_front, rrsp_back.
module resp_reply_stream_parser #(
    parameter int MAX_NEST   = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rrsp_byte_if.sink    i_byte_if,
    rrsp_event_if.source o_evt_if
);
    import rrsp_pkg::*;

    logic   q_valid, q_pop;
    t_item  q_item;
    t_event evt;

    rrsp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_byte_if.valid),
        .o_ready   (i_byte_if.ready),
        .i_byte    (i_byte_if.byte_in),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    rrsp_back #(
        .MAX_NEST   (MAX_NEST),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_evt_if.valid),
        .i_ready   (o_evt_if.ready),
        .o_event   (evt)
    );

    assign o_evt_if.event_res  = evt.event_res;
    assign o_evt_if.data_byte  = evt.data_byte;
    assign o_evt_if.number     = evt.number;
    assign o_evt_if.nest_depth = evt.nest_depth;
    assign o_evt_if.reply_done = evt.reply_done;
endmodule

FILE: tb/testbench.sv
// Testbench for the reply stream parser: byte driver, event monitor, predictor.
// Depends on rrsp_pkg, rrsp_byte_if, rrsp_event_if and resp_reply_stream_parser.
`timescale 1ns / 1ps

module testbench;
    import rrsp_pkg::*;

    localparam int NEST_MAX  = 8;
    localparam int CNT_BITS  = 32;
    localparam logic [63:0] CNT_MAX = (64'd1 << CNT_BITS) - 64'd1;

    logic i_clk;
    logic i_rst_n;

    rrsp_byte_if  byte_ch ();
    rrsp_event_if evt_ch ();

    resp_reply_stream_parser #(.MAX_NEST(NEST_MAX), .COUNT_BITS(CNT_BITS)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_if (byte_ch.sink),
        .o_evt_if  (evt_ch.source)
    );

    // Predictor state
    t_phase      ph;
    logic [63:0] acc;
    logic        neg;
    int unsigned ndig;
    logic [63:0] bulk_left;
    logic [63:0] lvl_left [NEST_MAX];
    int unsigned lvl;

    t_event      expected_events [$];
    logic [7:0]  pending_bytes [$];
    int          err_count;

    task automatic clear_parser();
        ph = PH_START; acc = '0; neg = 0; ndig = 0; bulk_left = '0; lvl = 0;
        for (int i = 0; i < NEST_MAX; i++) lvl_left[i] = '0;
    endtask

    function automatic void push_ev(logic [3:0] ev, logic [7:0] b, logic [63:0] n,
                                    logic done);
        t_event e;
        e.event_res = ev; e.data_byte = b; e.number = n;
        e.nest_depth = lvl[3:0]; e.reply_done = done;
        expected_events.insert(expected_events.size(), e);
    endfunction

    task automatic parse_fail();
        push_ev(EV_PERR, 8'd0, 64'd0, 1'b0);
        clear_parser();
    endtask

    // Completion: count at the top level, pop finished levels
    task automatic complete(logic [3:0] ev, logic [63:0] n);
        bit done;
        int unsigned d;
        d = lvl; done = 1;
        while (lvl > 0) begin
            lvl_left[lvl-1] = (lvl_left[lvl-1] - 64'd1) & CNT_MAX;
            if (lvl_left[lvl-1] != 0) begin
                done = 0;
                break;
            end
            lvl--;
        end
        begin
            int unsigned after;
            after = lvl; lvl = d;
            push_ev(ev, 8'd0, n, done);
            lvl = after;
        end
        ph = PH_START;
    endtask

    // Sign, digit and CR of a number; returns 0 on error
    function automatic bit num_byte(logic [7:0] c, t_phase lf_ph);
        logic [63:0] dg, lim;
        if (c == CH_CR) begin
            if (ndig == 0) return 0;
            ph = lf_ph;
            return 1;
        end
        if (c == CH_MINUS) begin
            if (neg || ndig != 0) return 0;
            neg = 1;
            return 1;
        end
        if (c >= "0" && c <= "9") begin
            dg = {56'd0, c - 8'h30};
            lim = neg ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
            if (acc > (lim - dg) / 64'd10) return 0;
            acc = acc * 64'd10 + dg;
            if (ndig < 31) ndig++;
            return 1;
        end
        return 0;
    endfunction

    function automatic logic [63:0] sval();
        return neg ? (64'd0 - acc) : acc;
    endfunction

    task automatic predict_byte(logic [7:0] c);
        case (ph)
            PH_START: begin
                acc = '0; neg = 0; ndig = 0;
                if (c == CH_PLUS) ph = PH_SIMPLE;
                else if (c == CH_MINUS) ph = PH_ERR;
                else if (c == CH_COLON) ph = PH_INT;
                else if (c == CH_DOLLR) ph = PH_BLEN;
                else if (c == CH_STAR) ph = PH_ALEN;
                else parse_fail();
            end
            PH_SIMPLE, PH_ERR: begin
                if (c == CH_CR) ph = (ph == PH_SIMPLE) ? PH_SIMPLE_LF : PH_ERR_LF;
                else if (c >= 8'd32 && c <= 8'd126)
                    push_ev(ph == PH_SIMPLE ? EV_SBYTE : EV_EBYTE, c, 64'd0, 1'b0);
                else parse_fail();
            end
            PH_SIMPLE_LF, PH_ERR_LF: begin
                if (c != CH_LF) parse_fail();
                else complete(ph == PH_SIMPLE_LF ? EV_SEND : EV_EEND, 64'd0);
            end
            PH_INT:  if (!num_byte(c, PH_INT_LF)) parse_fail();
            PH_BLEN: if (!num_byte(c, PH_BLEN_LF)) parse_fail();
            PH_ALEN: if (!num_byte(c, PH_ALEN_LF)) parse_fail();
            PH_INT_LF: begin
                if (c != CH_LF) parse_fail();
                else complete(EV_INT, sval());
            end
            PH_BLEN_LF: begin
                if (c != CH_LF) parse_fail();
                else if (neg && acc != 0) begin
                    if (acc == 64'd1) complete(EV_NULL, sval());
                    else parse_fail();
                end else if (acc > CNT_MAX) parse_fail();
                else begin
                    neg = 0; bulk_left = acc;
                    ph = (bulk_left == 0) ? PH_BCR : PH_BDATA;
                end
            end
            PH_BDATA: begin
                bulk_left = (bulk_left - 64'd1) & CNT_MAX;
                if (bulk_left == 0) ph = PH_BCR;
                push_ev(EV_BBYTE, c, 64'd0, 1'b0);
            end
            PH_BCR: begin
                if (c != CH_CR) parse_fail();
                else ph = PH_BLF;
            end
            PH_BLF: begin
                if (c != CH_LF) parse_fail();
                else complete(EV_BEND, acc);
            end
            PH_ALEN_LF: begin
                if (c != CH_LF) parse_fail();
                else if (acc == 0 || (neg && acc == 64'd1)) complete(EV_AEMPTY, sval());
                else if (neg || acc > CNT_MAX || lvl >= NEST_MAX) parse_fail();
                else begin
                    push_ev(EV_AOPEN, 8'd0, acc, 1'b0);
                    lvl_left[lvl] = acc;
                    lvl++;
                    ph = PH_START;
                end
            end
            default: parse_fail();
        endcase
    endtask

    // Stimulus helpers
    task automatic add_byte(logic [7:0] b);
        pending_bytes.insert(pending_bytes.size(), b);
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic put_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    task automatic put_text(bit is_err);
        int n;
        n = $urandom_range(0, 6);
        add_byte(is_err ? CH_MINUS : CH_PLUS);
        for (int i = 0; i < n; i++) add_byte(8'($urandom_range(32, 126)));
        put_crlf();
    endtask

    task automatic put_bulk();
        int n;
        n = $urandom_range(0, 5);
        if ($urandom_range(0, 9) == 0) begin
            put_str("$-1"); put_crlf();
            return;
        end
        put_str($sformatf("$%0d", n)); put_crlf();
        for (int i = 0; i < n; i++) add_byte(8'($urandom));
        put_crlf();
    endtask

    task automatic put_value(int depth);
        int k;
        k = $urandom_range(0, 9);
        if (k < 2) put_text(k == 1);
        else if (k < 4) begin
            put_str($sformatf(":%0d", $signed($urandom)));
            put_crlf();
        end else if (k < 6) put_bulk();
        else if (k < 7 && depth < 10) begin
            put_str(($urandom_range(0, 1) != 0) ? "*0" : "*-1"); put_crlf();
        end else if (depth < 10) begin
            int n;
            n = $urandom_range(1, 3);
            put_str($sformatf("*%0d", n)); put_crlf();
            for (int i = 0; i < n; i++) put_value(depth + 1);
        end else put_text(0);
    endtask

    // Clock and reset
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
    end

    // Byte driver
    int drv_wait;
    initial begin
        byte_ch.valid = 0;
        byte_ch.byte_in = '0;
        drv_wait = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) predict_byte(byte_ch.byte_in);
            if (!byte_ch.valid || byte_ch.ready) begin
                if (drv_wait > 0 || pending_bytes.size() == 0) begin
                    if (drv_wait > 0) drv_wait--;
                    byte_ch.valid <= 0;
                end else begin
                    byte_ch.byte_in <= pending_bytes.pop_front();
                    byte_ch.valid <= 1;
                    drv_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                    if ($urandom_range(0, 1) == 0) drv_wait = 0;
                end
            end
        end
    end

    // Event monitor
    int mon_wait;
    initial begin
        evt_ch.ready = 0;
        mon_wait = 0;
    end

    always @(posedge i_clk) begin
        t_event e;
        if (i_rst_n) begin
            if (evt_ch.valid && evt_ch.ready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected event %0d", evt_ch.event_res);
                    err_count++;
                end else begin
                    e = expected_events.pop_front();
                    if (evt_ch.event_res !== e.event_res) begin
                        $error("event_res exp %0d got %0d", e.event_res, evt_ch.event_res);
                        err_count++;
                    end
                    if (evt_ch.data_byte !== e.data_byte) begin
                        $error("data_byte exp %0h got %0h", e.data_byte, evt_ch.data_byte);
                        err_count++;
                    end
                    if (evt_ch.number !== e.number) begin
                        $error("number exp %0d got %0d", e.number, evt_ch.number);
                        err_count++;
                    end
                    if (evt_ch.nest_depth !== e.nest_depth) begin
                        $error("nest_depth exp %0d got %0d", e.nest_depth,
                               evt_ch.nest_depth);
                        err_count++;
                    end
                    if (evt_ch.reply_done !== e.reply_done) begin
                        $error("reply_done exp %0d got %0d", e.reply_done,
                               evt_ch.reply_done);
                        err_count++;
                    end
                end
                mon_wait = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 14);
            end
            if (mon_wait > 0) begin
                mon_wait--;
                evt_ch.ready <= 0;
            end else begin
                evt_ch.ready <= 1;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        err_count = 0;
        clear_parser();
        // Directed: each type, extremes, and each error case
        put_str("+OK"); put_crlf();
        put_str("-ERR x"); put_crlf();
        put_str(":9223372036854775807"); put_crlf();
        put_str(":-9223372036854775808"); put_crlf();
        put_str(":9223372036854775808");            // overflow
        put_str(":-0"); put_crlf();
        put_str("$0"); put_crlf(); put_crlf();
        put_str("$-1"); put_crlf();
        put_str("$-2"); put_crlf();                 // bad negative length
        put_str("$4294967296"); put_crlf();         // oversized length
        put_str("$2"); put_crlf();
        add_byte(8'h00); add_byte(8'hFF); put_crlf();
        put_str("*0"); put_crlf();
        put_str("*-1"); put_crlf();
        put_str("*2"); put_crlf(); put_str(":1"); put_crlf(); put_str("+a"); put_crlf();
        for (int i = 0; i < 9; i++) begin put_str("*1"); put_crlf(); end  // too deep
        put_str("?");                               // unknown type
        put_str("+a"); add_byte(8'h7F);             // bad text byte
        put_str("+a"); add_byte(CH_CR); put_str("x"); // missing LF
        put_str(":1-"); put_str(":"); put_crlf();   // malformed numbers
        put_str("*4294967295"); put_crlf(); put_str("!");
        // Random: mostly well-formed replies, some noise
        while (pending_bytes.size() < 1040) begin
            if ($urandom_range(0, 9) == 0) begin
                int n;
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) add_byte(8'($urandom));
            end else put_value(0);
        end
        wait (i_rst_n);
        wait (pending_bytes.size() == 0 && !byte_ch.valid);
        wait (expected_events.size() == 0);
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && expected_events.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
